FILE: hw/rtl/multi_waveform_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-waveform generator checker.
// Each macro expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_GENERATOR_ASSERT_SVH
`define MULTI_WAVEFORM_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("multi_waveform_generator check failed");

// Implication that holds a fixed number of cycles later.
`define MWG_ASSERT_LATER(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("multi_waveform_generator latency check failed");

`endif

FILE: hw/rtl/mwg_pkg.sv
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared types, constants and the quarter-wave sine entry function.
// ----------------------------------------------------------------------------
package mwg_pkg;

    localparam int unsigned SINE_INDEX_BITS_DEF = 10;
    localparam int unsigned SAMPLE_W            = 16;
    localparam int unsigned ENTRY_W             = 15;
    localparam int unsigned TIME_W              = 32;
    localparam int unsigned PHASE_W             = 32;
    localparam int unsigned PIPE_LATENCY        = 4;

    localparam logic [ENTRY_W-1:0]  FULL_SCALE     = 15'd16384;
    localparam logic [PHASE_W-1:0]  PHASE_HALF     = 32'h8000_0000;
    localparam logic [PHASE_W-1:0]  PHASE_STEP_RST = 32'd1288490;
    localparam logic [63:0]         HALF_PI_Q30    = 64'd1686629713;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_SAWTOOTH = 2'd2
    } shape_t;

    typedef enum logic {
        REG_WAVE_SHAPE = 1'b0,
        REG_PHASE_STEP = 1'b1
    } reg_index_t;

    // Quarter-wave entry k of a table with 2^bits steps, Q1.14, rounded.
    function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (HALF_PI_Q30 * 64'(k)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (sum + 64'sd32768) >>> 16;
        if (r > 64'sd16384)
        begin
            r = 64'sd16384;
        end
        return r[ENTRY_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/multi_waveform_generator.sv
// A word taken at a clock edge passes the time, phase, ROM/shape and sample
// registers and appears on sample/time_echo with done high. Throughput: one word per
// cycle; busy is never raised and done is never held off. The rate is set by
// the four-stage pipe around the phase multiplier and the registered sine ROM.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the register
// defaults: sine shape and a phase step of 1288490.
// ----------------------------------------------------------------------------
// multi_waveform_generator
// Direct digital synthesis of sine, square and sawtooth samples from a
// millisecond time stamp, with an APB-style register port.
// ----------------------------------------------------------------------------
module multi_waveform_generator #(
    parameter int unsigned SINE_INDEX_BITS = mwg_pkg::SINE_INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mwg_pkg::TIME_W-1:0]          time_ms,
    output logic                                done,
    output logic signed [mwg_pkg::SAMPLE_W-1:0] sample,
    output logic [mwg_pkg::TIME_W-1:0]          time_echo,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import mwg_pkg::*;

    localparam int unsigned ADDR_W     = SINE_INDEX_BITS + 1;
    localparam int unsigned SINE_DEPTH = (1 << SINE_INDEX_BITS) + 1;
    localparam logic [ADDR_W-1:0] SINE_FULL = ADDR_W'(1) << SINE_INDEX_BITS;

    logic [ENTRY_W-1:0] sine_rom [0:SINE_DEPTH-1];

    for (genvar k = 0; k < SINE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k, SINE_INDEX_BITS);
    end

    shape_t              shape_reg;
    logic [PHASE_W-1:0]  step_reg;
    logic                cfg_write;
    reg_index_t          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= SHAPE_SINE;
            step_reg  <= PHASE_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WAVE_SHAPE: shape_reg <= shape_t'(pwdata[1:0]);
                REG_PHASE_STEP: step_reg  <= pwdata;
                default:        step_reg  <= step_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_WAVE_SHAPE: prdata = {30'd0, shape_reg};
            REG_PHASE_STEP: prdata = step_reg;
            default:        prdata = 32'd0;
        endcase
    end

    assign busy = 1'b0;

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage payloads.
    logic [TIME_W-1:0]          time1_reg, time2_reg, time3_reg, time4_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         phase_next;
    logic [SINE_INDEX_BITS-1:0] idx;
    logic [ADDR_W-1:0]          addr_next;
    logic [ENTRY_W-1:0]         entry_reg;
    logic                       use_sine_reg, use_sine_next;
    logic                       negate_reg;
    logic signed [SAMPLE_W-1:0] alt_reg, alt_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_W-1:0] entry_s;

    assign phase_next = PHASE_W'(time1_reg * step_reg);
    assign idx        = phase_reg[29 -: SINE_INDEX_BITS];
    assign addr_next  = phase_reg[30] ? (SINE_FULL - {1'b0, idx}) : {1'b0, idx};

    always_comb
    begin
        use_sine_next = 1'b0;
        alt_next      = '0;
        case (shape_reg)
            SHAPE_SINE:
            begin
                use_sine_next = 1'b1;
            end
            SHAPE_SQUARE:
            begin
                alt_next = (phase_reg > PHASE_HALF) ? $signed({1'b0, FULL_SCALE})
                                                    : -$signed({1'b0, FULL_SCALE});
            end
            SHAPE_SAWTOOTH:
            begin
                alt_next = $signed({1'b0, phase_reg[31:17]}) - $signed({1'b0, FULL_SCALE});
            end
            default:
            begin
                alt_next = '0;
            end
        endcase
    end

    assign entry_s     = $signed({1'b0, entry_reg});
    assign sample_next = use_sine_reg ? (negate_reg ? -entry_s : entry_s) : alt_reg;

    always_ff @(posedge clk)
    begin
        time1_reg    <= time_ms;
        time2_reg    <= time1_reg;
        phase_reg    <= phase_next;
        time3_reg    <= time2_reg;
        entry_reg    <= sine_rom[addr_next];
        use_sine_reg <= use_sine_next;
        negate_reg   <= phase_reg[31];
        alt_reg      <= alt_next;
        time4_reg    <= time3_reg;
        sample_reg   <= sample_next;
    end

    assign done      = v4_reg;
    assign sample    = sample_reg;
    assign time_echo = time4_reg;

endmodule

FILE: hw/rtl/mwg_checker.sv
// ----------------------------------------------------------------------------
// mwg_checker
// Port-level checks of the waveform generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_waveform_generator_assert.svh"

module mwg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [mwg_pkg::TIME_W-1:0]          time_ms,
    input logic                                done,
    input logic signed [mwg_pkg::SAMPLE_W-1:0] sample,
    input logic [mwg_pkg::TIME_W-1:0]          time_echo
);
    import mwg_pkg::*;

    logic signed [SAMPLE_W-1:0] pos_full;

    assign pos_full = $signed({1'b0, FULL_SCALE});

    `MWG_ASSERT_NOW(a_sample_range, done, (sample <= pos_full) && (sample >= -pos_full))
    `MWG_ASSERT_LATER(a_word_done, start && !busy, PIPE_LATENCY, done)
    `MWG_ASSERT_LATER(a_no_extra_done, !(start && !busy), PIPE_LATENCY, !done)
    `MWG_ASSERT_LATER(a_time_echo, start && !busy, PIPE_LATENCY,
                      time_echo == $past(time_ms, PIPE_LATENCY))

endmodule

bind multi_waveform_generator mwg_checker u_mwg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .time_ms   (time_ms),
    .done      (done),
    .sample    (sample),
    .time_echo (time_echo)
);

FILE: dv/mwg_sample_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mwg_sample_check
// Watches the command, result and register channels of the multi-waveform
// generator. It keeps its own copy of the wave shape and phase step, predicts
// the sample and time echo of every accepted word, and compares each result
// word with the oldest prediction. It reports the failure count and the number
// of words still in flight to the testbench top.
// ----------------------------------------------------------------------------
module mwg_sample_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [mwg_pkg::TIME_W-1:0]          time_ms,
    input  logic                                done,
    input  logic signed [mwg_pkg::SAMPLE_W-1:0] sample,
    input  logic [mwg_pkg::TIME_W-1:0]          time_echo,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                pready,
    output int                                  fail_count,
    output int                                  pending_words
);
    import mwg_pkg::*;

    localparam int unsigned INDEX_BITS   = SINE_INDEX_BITS_DEF;
    localparam int unsigned TABLE_LAST   = 1 << INDEX_BITS;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level;
        logic [TIME_W-1:0]          stamp;
    } wave_word_t;

    wave_word_t         expected_samples [$];
    wave_word_t         want;
    int                 quarter_sine [0:TABLE_LAST];
    logic [1:0]         shape_reg;
    logic [PHASE_W-1:0] step_reg;

    // The quarter-wave table is built from a Taylor series worked in Q30.
    initial
    begin : build_quarter_sine
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k <= TABLE_LAST; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> INDEX_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            sum = (sum + 32768) >>> 16;
            if (sum > int'(FULL_SCALE))
            begin
                sum = int'(FULL_SCALE);
            end
            quarter_sine[k] = int'(sum);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] sample_at_time(input logic [TIME_W-1:0] t);
        logic [63:0]        product;
        logic [PHASE_W-1:0] phase;
        int unsigned        index;
        int                 value;
        product = 64'(t) * 64'(step_reg);
        phase   = product[PHASE_W-1:0];
        case (shape_reg)
            SHAPE_SINE:
            begin
                index = (phase >> (30 - INDEX_BITS)) & (TABLE_LAST - 1);
                value = phase[30] ? quarter_sine[TABLE_LAST - index] : quarter_sine[index];
                if (phase[31])
                begin
                    value = -value;
                end
            end
            SHAPE_SQUARE:
            begin
                value = (phase > PHASE_HALF) ? int'(FULL_SCALE) : -int'(FULL_SCALE);
            end
            SHAPE_SAWTOOTH:
            begin
                value = int'(phase >> 17) - int'(FULL_SCALE);
            end
            default:
            begin
                value = 0;
            end
        endcase
        return value[SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= SHAPE_SINE;
            step_reg  <= PHASE_STEP_RST;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[2]))
                    REG_WAVE_SHAPE: shape_reg <= pwdata[1:0];
                    REG_PHASE_STEP: step_reg  <= pwdata;
                endcase
            end
            if (start && !busy)
            begin
                expected_samples.push_back('{sample_at_time(time_ms), time_ms});
            end
            if (done)
            begin
                if (expected_samples.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected word: sample %0d time_echo %08h",
                                 sample, time_echo);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want.level || time_echo !== want.stamp)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("word mismatch: sample exp %0d got %0d, time_echo exp %08h got %08h",
                                     want.level, sample, want.stamp, time_echo);
                        end
                    end
                end
            end
            pending_words = expected_samples.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives time stamps into the multi-waveform generator under a series of
// wave shape and phase step settings written over the register port, first a
// directed set at the quadrant, half-cycle and range edges, then random words
// with random idle gaps or none. The sample checker beside the block predicts
// and compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import mwg_pkg::*;

    localparam logic [1:0]  SHAPE_MUTED       = 2'd3;
    localparam int unsigned STALL_LIMIT       = 1000;
    localparam int unsigned SETTING_COUNT     = 16;
    localparam int unsigned WORDS_PER_SETTING = 100;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [TIME_W-1:0]          time_ms;
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          time_echo;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    int                         fail_count;
    int                         pending_words;
    int unsigned                stall_cycles = 0;
    logic [TIME_W-1:0]          time_list [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multi_waveform_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .time_ms   (time_ms),
        .done      (done),
        .sample    (sample),
        .time_echo (time_echo),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    mwg_sample_check i_sample_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .time_ms       (time_ms),
        .done          (done),
        .sample        (sample),
        .time_echo     (time_echo),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input reg_index_t index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A gap of zero keeps start high so that the next word follows at once.
    task automatic send_word(input logic [TIME_W-1:0] t, input int unsigned gap);
        @(negedge clk);
        start   <= 1'b1;
        time_ms <= t;
        do @(posedge clk); while (busy);
        if (gap != 0)
        begin
            @(negedge clk);
            start   <= 1'b0;
            time_ms <= $urandom();
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Registers are only written once every word in flight has come back.
    task automatic run_setting(input logic [1:0] shape, input logic [31:0] step,
                               input bit no_idle);
        int unsigned gap;
        @(negedge clk);
        wait (pending_words == 0);
        write_reg(REG_WAVE_SHAPE, {30'($urandom()), shape});
        write_reg(REG_PHASE_STEP, step);
        foreach (time_list[i])
        begin
            gap = no_idle ? 0 : $urandom_range(0, 15);
            if (i == time_list.size() - 1 && gap == 0)
            begin
                gap = 1;
            end
            send_word(time_list[i], gap);
        end
    endtask

    initial
    begin
        logic [31:0] step;
        rst_n   = 1'b0;
        start   = 1'b0;
        time_ms = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(32'h0000_0000, 0);
        send_word(32'hFFFF_FFFF, 0);
        send_word(32'd1000, 1);

        time_list = '{32'h0000_0000, 32'h0010_0000, 32'h3FFF_FFFF, 32'h4000_0000,
                      32'h7FF0_0000, 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF};
        run_setting(SHAPE_SINE, 32'd1, 1'b0);
        time_list = '{32'h8000_0000, 32'h8000_0001, 32'h0000_0000, 32'hFFFF_FFFF};
        run_setting(SHAPE_SQUARE, 32'd1, 1'b0);
        time_list = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF};
        run_setting(SHAPE_SAWTOOTH, 32'd1, 1'b0);
        time_list = '{32'h1234_5678, 32'hFFFF_FFFF};
        run_setting(SHAPE_MUTED, 32'hFFFF_FFFF, 1'b0);
        time_list = '{32'hFFFF_FFFF};
        run_setting(SHAPE_SINE, 32'd0, 1'b0);
        time_list = '{32'h0000_0001, 32'h4000_0000};
        run_setting(SHAPE_SINE, 32'hFFFF_FFFF, 1'b0);

        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            case ($urandom_range(0, 5))
                0:       step = 32'd0;
                1:       step = 32'hFFFF_FFFF;
                2:       step = 32'd1;
                3:       step = PHASE_STEP_RST;
                default: step = $urandom();
            endcase
            time_list = {};
            repeat (WORDS_PER_SETTING)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    time_list.push_back($urandom());
                    2:       time_list.push_back($urandom_range(0, 65535));
                    default: time_list.push_back($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
                endcase
            end
            run_setting((s < 4) ? 2'(s) : 2'($urandom_range(0, 3)), step, (s % 4) == 1);
        end

        @(negedge clk);
        wait (pending_words == 0);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
